>>> src/gcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// gcd_pkg: widths, fixed-point constants and the CORDIC arctangent table
// shared by the great-circle distance pipeline. No dependencies.
package gcd_pkg;

	localparam int CORDIC_STEPS_DEF = 24;

	localparam int LAT_W    = 31;
	localparam int LON_W    = 32;
	localparam int RADIUS_W = 23;
	localparam int DIST_W   = 25;

	localparam int BAU_W     = 32;
	localparam int TRIG_W    = 32;
	localparam int ROT_W     = 34;
	localparam int ATAN_W    = 30;
	localparam int ANGLE_W   = 34;
	localparam int ROOT_IN_W = 61;
	localparam int ROOT_W    = 31;
	localparam int ROOT_STEPS = 31;
	localparam int VEC_W     = 58;
	localparam int VEC_SHIFT = 24;
	localparam int Z_W       = 31;
	localparam int PROD_W    = 54;

	localparam int NUMER_W       = 54;
	localparam int REM_W         = 22;
	localparam int QUOT_W        = 33;
	localparam int DIV_STAGES    = 3;

	localparam logic [RADIUS_W-1:0]       RADIUS_RESET = 23'd6371000;
	localparam logic signed [35:0]        TURN         = 36'sd3600000000;
	localparam logic [REM_W-1:0]          BAU_DIV      = 22'd3515625;
	localparam logic [QUOT_W-1:0]         BAU_RECIP    = 33'd5124095576;
	localparam logic [NUMER_W-1:0]        BAU_HALF     = 54'd1757812;
	localparam logic signed [ROT_W-1:0]   CORDIC_START = 34'sd652032874;
	localparam logic [31:0]               PI_Q30       = 32'd3373259426;
	localparam logic [ROOT_IN_W-1:0]      ONE_Q60      = 61'h1000_0000_0000_0000;
	localparam logic [Z_W-1:0]            QUARTER_BAU  = 31'h4000_0000;
	localparam logic [DIST_W-1:0]         DIST_MAX     = 25'd22000000;

	// atan(2^-i) in binary angle units, 2^32 per turn, rounded
	function automatic logic [ATAN_W-1:0] atan_bau(input int idx);
		logic [ATAN_W-1:0] val;
		unique case (idx)
			0:  val = 30'd536870912;
			1:  val = 30'd316933406;
			2:  val = 30'd167458907;
			3:  val = 30'd85004756;
			4:  val = 30'd42667331;
			5:  val = 30'd21354465;
			6:  val = 30'd10679838;
			7:  val = 30'd5340245;
			8:  val = 30'd2670163;
			9:  val = 30'd1335087;
			10: val = 30'd667544;
			11: val = 30'd333772;
			12: val = 30'd166886;
			13: val = 30'd83443;
			14: val = 30'd41722;
			15: val = 30'd20861;
			16: val = 30'd10430;
			17: val = 30'd5215;
			18: val = 30'd2608;
			19: val = 30'd1304;
			20: val = 30'd652;
			21: val = 30'd326;
			22: val = 30'd163;
			23: val = 30'd81;
			24: val = 30'd41;
			25: val = 30'd20;
			26: val = 30'd10;
			27: val = 30'd5;
			28: val = 30'd3;
			29: val = 30'd1;
			30: val = 30'd1;
			default: val = '0;
		endcase
		return val;
	endfunction

endpackage
`default_nettype wire

>>> src/gcd_sincos.sv
`timescale 1ns / 1ps
`default_nettype none
// gcd_sincos: pipelined rotation CORDIC, one iteration per stage, giving
// sine and cosine in Q30 of a binary angle. Depends on gcd_pkg.
module gcd_sincos
	import gcd_pkg::*;
#(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [BAU_W-1:0]         angle,
	output logic signed [TRIG_W-1:0] sine,
	output logic signed [TRIG_W-1:0] cosine
);

	logic [BAU_W-1:0]       quad;
	logic [BAU_W-1:0]       folded;
	logic                   flip_s0;
	logic signed [ROT_W-1:0] z_s0;

	logic signed [ROT_W-1:0] x_s [STEPS];
	logic signed [ROT_W-1:0] y_s [STEPS];
	logic signed [ROT_W-1:0] z_s [STEPS];
	logic                    f_s [STEPS];

	logic signed [ROT_W-1:0] neg_x;
	logic signed [ROT_W-1:0] neg_y;

	assign quad   = angle + 32'h4000_0000;
	assign folded = quad[BAU_W-1] ? (angle ^ 32'h8000_0000) : angle;

	always_ff @(posedge clk) begin
		if (en) begin
			flip_s0 <= quad[BAU_W-1];
			z_s0    <= {{(ROT_W-BAU_W){folded[BAU_W-1]}}, folded};
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_iter
		localparam logic signed [ROT_W-1:0] AT = {{(ROT_W-ATAN_W){1'b0}}, atan_bau(i)};
		logic signed [ROT_W-1:0] xi, yi, zi;
		logic                    fi;
		if (i == 0) begin : g_first
			assign xi = CORDIC_START;
			assign yi = '0;
			assign zi = z_s0;
			assign fi = flip_s0;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign fi = f_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				f_s[i] <= fi;
				if (zi >= 0) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - AT;
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + AT;
				end
			end
		end
	end

	assign neg_x = -x_s[STEPS-1];
	assign neg_y = -y_s[STEPS-1];

	always_ff @(posedge clk) begin
		if (en) begin
			sine   <= f_s[STEPS-1] ? neg_y[TRIG_W-1:0] : y_s[STEPS-1][TRIG_W-1:0];
			cosine <= f_s[STEPS-1] ? neg_x[TRIG_W-1:0] : x_s[STEPS-1][TRIG_W-1:0];
		end
	end

endmodule
`default_nettype wire

>>> src/gcd_root.sv
`timescale 1ns / 1ps
`default_nettype none
// gcd_root: pipelined shift-and-subtract square root of a Q60 value,
// one result bit per stage, floor result in Q30. Depends on gcd_pkg.
module gcd_root
	import gcd_pkg::*;
(
	input  logic                 clk,
	input  logic                 en,
	input  logic [ROOT_IN_W-1:0] radicand,
	output logic [ROOT_W-1:0]    root
);

	localparam int RW = ROOT_IN_W + 1;

	logic [ROOT_IN_W-1:0] v_s [ROOT_STEPS];
	logic [RW-1:0]        r_s [ROOT_STEPS];

	for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_iter
		localparam logic [RW-1:0] BIT = RW'(1) << (ROOT_IN_W - 1 - 2 * i);
		logic [ROOT_IN_W-1:0] vi;
		logic [RW-1:0]        ri;
		logic [RW-1:0]        trial;
		if (i == 0) begin : g_first
			assign vi = radicand;
			assign ri = '0;
		end else begin : g_next
			assign vi = v_s[i-1];
			assign ri = r_s[i-1];
		end
		assign trial = ri + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, vi} >= trial) begin
					v_s[i] <= vi - trial[ROOT_IN_W-1:0];
					r_s[i] <= (ri >> 1) + BIT;
				end else begin
					v_s[i] <= vi;
					r_s[i] <= ri >> 1;
				end
			end
		end
	end

	assign root = r_s[ROOT_STEPS-1][ROOT_W-1:0];

endmodule
`default_nettype wire

>>> src/great_circle_distance_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Great-circle distance between two positions by the haversine formula.
// Input channel: in_valid / in_stall with the two latitudes and longitudes
//   in signed 1e-7 degree; an item is taken when in_valid is high and
//   in_stall low.
// Output channel: out_valid / out_stall with distance_m in whole metres,
//   saturated at 22000000; the item leaves when out_valid is high and
//   out_stall low.
// Configuration: cfg_valid / cfg_ready with earth_radius_m; cfg_ready is
//   always high. Write only while no item is in flight.
// Pipeline: the angle division stages, the rotation and vectoring CORDIC
//   pipelines and the 31-stage square roots.
// Throughput: one item per cycle while in_stall is low.
// Reset: all valid bits clear, the radius returns to 6371000.
// Stall: a held result sits in the output register; one more item goes to
//   a skid register, after which in_stall rises and the whole pipeline
//   holds until the output drains.
// Depends on gcd_pkg, gcd_sincos and gcd_root.
module great_circle_distance_top
	import gcd_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [LAT_W-1:0]    first_latitude,
	input  logic signed [LON_W-1:0]    first_longitude,
	input  logic signed [LAT_W-1:0]    second_latitude,
	input  logic signed [LON_W-1:0]    second_longitude,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [DIST_W-1:0]          distance_m,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [RADIUS_W-1:0]        earth_radius_m
);

	localparam int PIPE_DEPTH = 2 + DIV_STAGES + (CORDIC_STEPS + 2) + 4 + ROOT_STEPS
		+ CORDIC_STEPS + 4;

	localparam int RCP_SHIFT = NUMER_W - 32;
	localparam logic [NUMER_W-1:0] DIV_X1 = NUMER_W'(BAU_DIV);
	localparam logic [NUMER_W-1:0] DIV_X2 = DIV_X1 << 1;
	localparam logic [NUMER_W-1:0] DIV_X3 = DIV_X2 + DIV_X1;

	function automatic logic [NUMER_W-1:0] bau_numer(input logic signed [35:0] v,
		input logic wide);
		logic signed [35:0]  r;
		logic [NUMER_W-1:0]  u;
		priority if (v < -TURN) begin
			r = v + (TURN <<< 1);
		end else if (v < 0) begin
			r = v + TURN;
		end else if (v >= TURN) begin
			r = v - TURN;
		end else begin
			r = v;
		end
		u = {{(NUMER_W-BAU_W){1'b0}}, r[BAU_W-1:0]};
		return (wide ? (u << 22) : (u << 21)) + BAU_HALF;
	endfunction

	logic                   en;
	logic [PIPE_DEPTH-1:0]  vld_q;
	logic [RADIUS_W-1:0]    radius_q;
	logic                   out_valid_q;
	logic                   skid_valid_q;
	logic [DIST_W-1:0]      dist_q;
	logic [DIST_W-1:0]      skid_q;
	logic                   last_v;

	assign en        = !skid_valid_q;
	assign in_stall  = skid_valid_q;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign distance_m = dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radius_q <= earth_radius_m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid};
		end
	end

	// differences and raw latitudes
	logic [LAT_W:0]       dlat_s1;
	logic [LON_W:0]       dlon_s1;
	logic [LAT_W-1:0]     lat1_s1;
	logic [LAT_W-1:0]     lat2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dlat_s1 <= {second_latitude[LAT_W-1], second_latitude}
				- {first_latitude[LAT_W-1], first_latitude};
			dlon_s1 <= {second_longitude[LON_W-1], second_longitude}
				- {first_longitude[LON_W-1], first_longitude};
			lat1_s1 <= first_latitude;
			lat2_s1 <= second_latitude;
		end
	end

	// wrap to one turn, form the rounded numerators, divide by reciprocal
	logic [NUMER_W-1:0]  numer [4];
	logic [NUMER_W-1:0]  numer_s2 [4];
	logic [NUMER_W-1:0]  numer_s3 [4];
	logic [QUOT_W+31:0]  prod_s3 [4];
	logic [NUMER_W-1:0]  numer_s4 [4];
	logic [QUOT_W-1:0]   q0_s4 [4];
	logic [NUMER_W-1:0]  qd_s4 [4];
	logic [QUOT_W-1:0]   q_s5 [4];

	always_comb begin
		numer[0] = bau_numer({{4{dlat_s1[LAT_W]}}, dlat_s1}, 1'b0);
		numer[1] = bau_numer({{3{dlon_s1[LON_W]}}, dlon_s1}, 1'b0);
		numer[2] = bau_numer({{5{lat1_s1[LAT_W-1]}}, lat1_s1}, 1'b1);
		numer[3] = bau_numer({{5{lat2_s1[LAT_W-1]}}, lat2_s1}, 1'b1);
	end

	for (genvar k = 0; k < 4; k++) begin : g_div
		logic [NUMER_W-1:0] rem_c;
		assign rem_c = numer_s4[k] - qd_s4[k];
		always_ff @(posedge clk) begin
			if (en) begin
				numer_s2[k] <= numer[k];
				numer_s3[k] <= numer_s2[k];
				prod_s3[k]  <= (QUOT_W+32)'(numer_s2[k][NUMER_W-1:RCP_SHIFT])
					* (QUOT_W+32)'(BAU_RECIP);
				numer_s4[k] <= numer_s3[k];
				q0_s4[k]    <= prod_s3[k][QUOT_W+31:32];
				qd_s4[k]    <= NUMER_W'(prod_s3[k][QUOT_W+31:32]) * NUMER_W'(BAU_DIV);
				priority if (rem_c >= DIV_X3) begin
					q_s5[k] <= q0_s4[k] + QUOT_W'(3);
				end else if (rem_c >= DIV_X2) begin
					q_s5[k] <= q0_s4[k] + QUOT_W'(2);
				end else if (rem_c >= DIV_X1) begin
					q_s5[k] <= q0_s4[k] + QUOT_W'(1);
				end else begin
					q_s5[k] <= q0_s4[k];
				end
			end
		end
	end

	// sines of the half differences, cosines of the latitudes
	logic signed [TRIG_W-1:0] sin_w [4];
	logic signed [TRIG_W-1:0] cos_w [4];

	for (genvar k = 0; k < 4; k++) begin : g_trig
		gcd_sincos #(
			.STEPS (CORDIC_STEPS)
		) u_sincos (
			.clk    (clk),
			.en     (en),
			.angle  (q_s5[k][BAU_W-1:0]),
			.sine   (sin_w[k]),
			.cosine (cos_w[k])
		);
	end

	// haversine term
	logic signed [63:0]       c12_p1, s1sq_p1, s1sq_p2, s1sq_p3;
	logic signed [TRIG_W-1:0] s2_p1, s2_p2;
	logic signed [63:0]       mprod_p2, mm_p3;
	logic signed [TRIG_W-1:0] p_w, m_w;
	logic signed [63:0]       asum;
	logic [ROOT_IN_W-1:0]     acl;
	logic [ROOT_IN_W-1:0]     a_p4, b_p4;

	assign p_w = c12_p1[61:30];
	assign m_w = mprod_p2[61:30];

	always_comb begin
		asum = s1sq_p3 + mm_p3;
		priority if (asum < 0) begin
			acl = '0;
		end else if (asum > $signed({3'b000, ONE_Q60})) begin
			acl = ONE_Q60;
		end else begin
			acl = asum[ROOT_IN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c12_p1   <= cos_w[2] * cos_w[3];
			s1sq_p1  <= sin_w[0] * sin_w[0];
			s2_p1    <= sin_w[1];
			mprod_p2 <= s2_p1 * p_w;
			s1sq_p2  <= s1sq_p1;
			s2_p2    <= s2_p1;
			mm_p3    <= m_w * s2_p2;
			s1sq_p3  <= s1sq_p2;
			a_p4     <= acl;
			b_p4     <= ONE_Q60 - acl;
		end
	end

	logic [ROOT_W-1:0] ra_w, rb_w;

	gcd_root u_root_a (
		.clk      (clk),
		.en       (en),
		.radicand (a_p4),
		.root     (ra_w)
	);

	gcd_root u_root_b (
		.clk      (clk),
		.en       (en),
		.radicand (b_p4),
		.root     (rb_w)
	);

	// vectoring CORDIC for the central angle
	logic signed [VEC_W-1:0]   vx_init, vy_init;
	logic signed [VEC_W-1:0]   vx_s [CORDIC_STEPS];
	logic signed [VEC_W-1:0]   vy_s [CORDIC_STEPS];
	logic signed [ANGLE_W-1:0] vz_s [CORDIC_STEPS];

	assign vx_init = {{(VEC_W-ROOT_W-VEC_SHIFT){1'b0}}, rb_w, {VEC_SHIFT{1'b0}}};
	assign vy_init = {{(VEC_W-ROOT_W-VEC_SHIFT){1'b0}}, ra_w, {VEC_SHIFT{1'b0}}};

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
		localparam logic signed [ANGLE_W-1:0] AT = {{(ANGLE_W-ATAN_W){1'b0}}, atan_bau(i)};
		logic signed [VEC_W-1:0]   xi, yi;
		logic signed [ANGLE_W-1:0] zi;
		if (i == 0) begin : g_first
			assign xi = vx_init;
			assign yi = vy_init;
			assign zi = '0;
		end else begin : g_next
			assign xi = vx_s[i-1];
			assign yi = vy_s[i-1];
			assign zi = vz_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (yi >= 0) begin
					vx_s[i] <= xi + (yi >>> i);
					vy_s[i] <= yi - (xi >>> i);
					vz_s[i] <= zi + AT;
				end else begin
					vx_s[i] <= xi - (yi >>> i);
					vy_s[i] <= yi + (xi >>> i);
					vz_s[i] <= zi - AT;
				end
			end
		end
	end

	// scale by radius and pi, round, saturate
	logic signed [ANGLE_W-1:0] zf;
	logic [Z_W-1:0]            z_m1;
	logic [PROD_W-1:0]         t_m2;
	logic [PROD_W-1:0]         hi_m3;
	logic [63:0]               lo_m3;
	logic [PROD_W:0]           dsum;
	logic [PROD_W-28:0]        dround;
	logic [DIST_W-1:0]         dist_m4;

	assign zf = vz_s[CORDIC_STEPS-1];

	always_comb begin
		dsum   = {1'b0, hi_m3} + (PROD_W+1)'(lo_m3[63:32]) + ((PROD_W+1)'(1) << 27);
		dround = dsum[PROD_W:28];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (zf < 0) begin
				z_m1 <= '0;
			end else if (zf > $signed({3'b000, QUARTER_BAU})) begin
				z_m1 <= QUARTER_BAU;
			end else begin
				z_m1 <= zf[Z_W-1:0];
			end
			t_m2    <= PROD_W'(radius_q) * PROD_W'(z_m1);
			hi_m3   <= PROD_W'(t_m2[PROD_W-1:32]) * PROD_W'(PI_Q30);
			lo_m3   <= 64'(t_m2[31:0]) * 64'(PI_Q30);
			dist_m4 <= (dround > (PROD_W-27)'(DIST_MAX)) ? DIST_MAX : dround[DIST_W-1:0];
		end
	end

	// output register and skid
	assign last_v = vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && out_stall) begin
			if (en && last_v) begin
				skid_valid_q <= 1'b1;
			end
		end else begin
			out_valid_q  <= skid_valid_q || (en && last_v);
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && out_stall) begin
			if (en && last_v) begin
				skid_q <= dist_m4;
			end
		end else if (skid_valid_q) begin
			dist_q <= skid_q;
		end else begin
			dist_q <= dist_m4;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds an item while the output is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid filled without a held output");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline valid bits moved while held");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (dist_q <= DIST_MAX))
		else $error("distance above saturation bound");

endmodule
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: drives position pairs into great_circle_distance_top and checks each
// distance against a fixed-point haversine predictor kept in this file.
// Depends on gcd_pkg and the great_circle_distance_top RTL.
module tb_top;
	import gcd_pkg::*;

	typedef struct {
		logic signed [LAT_W-1:0] lat1;
		logic signed [LON_W-1:0] lon1;
		logic signed [LAT_W-1:0] lat2;
		logic signed [LON_W-1:0] lon2;
	} pos_pair_t;

	localparam int STEPS = 24;
	localparam int LATENCY = 46 + 2 * STEPS;
	localparam longint unsigned PI_Q29 = 64'd1686629713;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [LAT_W-1:0] first_latitude = '0;
	logic signed [LON_W-1:0] first_longitude = '0;
	logic signed [LAT_W-1:0] second_latitude = '0;
	logic signed [LON_W-1:0] second_longitude = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [DIST_W-1:0] distance_m;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [RADIUS_W-1:0] earth_radius_m = '0;

	pos_pair_t pending_pairs[$];
	pos_pair_t cur_pair;
	logic [DIST_W-1:0] expected_dist[$];
	longint atan_tab[STEPS];
	logic [RADIUS_W-1:0] radius_cur = RADIUS_RESET;
	bit calm = 0;
	int hold_token = 0, hold_seen = 0, hold_cnt = 0;
	int send_gap = 0, stall_burst = 0;
	int mismatches = 0, checked = 0, accepted = 0;

	great_circle_distance_top #(.CORDIC_STEPS(STEPS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.first_latitude(first_latitude), .first_longitude(first_longitude),
		.second_latitude(second_latitude), .second_longitude(second_longitude),
		.out_valid(out_valid), .out_stall(out_stall), .distance_m(distance_m),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .earth_radius_m(earth_radius_m)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic longint unsigned angle_units(longint deg_e7, int shift);
		longint r;
		longint unsigned u;
		r = deg_e7 % 64'sd3600000000;
		if (r < 0) r += 64'sd3600000000;
		u = r;
		return (((u << shift) + 64'd1757812) / 64'd3515625) & 64'hFFFF_FFFF;
	endfunction

	function automatic void rotate(input longint unsigned ang, output longint s,
		output longint c);
		logic [31:0] a;
		longint x, y, z, dx, dy;
		bit flip;
		a = ang[31:0];
		x = 652032874;
		y = 0;
		flip = ((a + 32'h4000_0000) >> 31) != 0;
		if (flip) a = a - 32'h8000_0000;
		z = longint'($signed(a));
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tab[i];
			end else begin
				x += dx; y -= dy; z += atan_tab[i];
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic longint unsigned sqrt_q60(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 60;
		for (int i = 0; i < 31; i++) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [DIST_W-1:0] haversine_dist(pos_pair_t pp,
		logic [RADIUS_W-1:0] radius);
		longint la1, lo1, la2, lo2, s1, s2, c1, c2, junk, p, m, a, vx, vy, z, dx, dy;
		longint unsigned t, hi, lo, d;
		la1 = pp.lat1; lo1 = pp.lon1; la2 = pp.lat2; lo2 = pp.lon2;
		rotate(angle_units(la2 - la1, 21), s1, junk);
		rotate(angle_units(lo2 - lo1, 21), s2, junk);
		rotate(angle_units(la1, 22), junk, c1);
		rotate(angle_units(la2, 22), junk, c2);
		p = (c1 * c2) >>> 30;
		m = (s2 * p) >>> 30;
		a = s1 * s1 + m * s2;
		if (a < 0) a = 0;
		if (a > (64'sd1 <<< 60)) a = 64'sd1 <<< 60;
		vy = sqrt_q60(a) << 24;
		vx = sqrt_q60((64'd1 << 60) - a) << 24;
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (vy >= 0) begin
				vx += dx; vy -= dy; z += atan_tab[i];
			end else begin
				vx -= dx; vy += dy; z -= atan_tab[i];
			end
		end
		if (z < 0) z = 0;
		if (z > (64'sd1 <<< 30)) z = 64'sd1 <<< 30;
		t = longint'(radius) * z;
		hi = (t >> 32) * 64'd3373259426;
		lo = (t & 64'hFFFF_FFFF) * 64'd3373259426;
		d = (hi + (lo >> 32) + (64'd1 << 27)) >> 28;
		if (d > 64'd22000000) d = 64'd22000000;
		return d[DIST_W-1:0];
	endfunction

	function automatic logic signed [LAT_W-1:0] any_lat();
		if ($urandom_range(0, 4) == 0) return $urandom;
		return longint'($urandom_range(0, 1800000000)) - 900000000;
	endfunction

	function automatic logic signed [LON_W-1:0] any_lon();
		if ($urandom_range(0, 4) == 0) return $urandom;
		return longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
	endfunction

	function automatic pos_pair_t random_pair();
		pos_pair_t pp;
		pp.lat1 = any_lat();
		pp.lon1 = any_lon();
		case ($urandom_range(0, 3))
			0: begin
				pp.lat2 = pp.lat1 + $signed($urandom_range(0, 20000)) - 10000;
				pp.lon2 = pp.lon1 + $signed($urandom_range(0, 20000)) - 10000;
			end
			1: begin
				pp.lat2 = -pp.lat1 + $signed($urandom_range(0, 2000)) - 1000;
				pp.lon2 = pp.lon1 + 1800000000 + $signed($urandom_range(0, 2000)) - 1000;
			end
			default: begin
				pp.lat2 = any_lat();
				pp.lon2 = any_lon();
			end
		endcase
		return pp;
	endfunction

	function automatic void add_pair(longint la1, longint lo1, longint la2, longint lo2);
		pos_pair_t pp;
		pp.lat1 = la1; pp.lon1 = lo1; pp.lat2 = la2; pp.lon2 = lo2;
		pending_pairs.push_back(pp);
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			send_gap <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				expected_dist.push_back(haversine_dist(cur_pair, radius_cur));
				accepted <= accepted + 1;
			end
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				send_gap <= $urandom_range(0, 5);
				in_valid <= 0;
			end else if (pending_pairs.size() > 0) begin
				cur_pair = pending_pairs.pop_front();
				first_latitude <= cur_pair.lat1;
				first_longitude <= cur_pair.lon1;
				second_latitude <= cur_pair.lat2;
				second_longitude <= cur_pair.lon2;
				in_valid <= 1;
			end else begin
				in_valid <= 0;
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_dist.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected distance %0d", distance_m);
				end else begin
					logic [DIST_W-1:0] want;
					want = expected_dist.pop_front();
					checked++;
					if (distance_m !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("distance mismatch: expected %0d got %0d",
								want, distance_m);
					end
				end
			end
			if (hold_seen != hold_token) begin
				hold_seen <= hold_token;
				hold_cnt <= 400;
				out_stall <= 1;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				out_stall <= 1;
			end else if (stall_burst > 0) begin
				stall_burst <= stall_burst - 1;
				out_stall <= 1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_burst <= $urandom_range(0, 5);
				out_stall <= 1;
			end else begin
				out_stall <= 0;
			end
		end
	end

	task automatic drain();
		while (pending_pairs.size() > 0 || in_valid || expected_dist.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_radius(logic [RADIUS_W-1:0] r);
		@(posedge clk);
		cfg_valid <= 1;
		earth_radius_m <= r;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		radius_cur = r;
	endtask

	initial begin
		logic [RADIUS_W-1:0] radii[6];
		longint acc;
		longint unsigned pw;
		radii = '{23'd7000000, 23'd6000000, 23'h7FFFFF, 23'd0, 23'd6371000, 23'd6378137};
		atan_tab[0] = 64'sd1 <<< 29;
		for (int i = 1; i < STEPS; i++) begin
			acc = 0;
			pw = 64'd1 << (60 - i);
			for (int k = 0; k < 40 && pw != 0; k++) begin
				acc += (k & 1) ? -longint'(pw / (2 * k + 1)) : longint'(pw / (2 * k + 1));
				pw = pw >> (2 * i);
			end
			atan_tab[i] = (longint'(acc) + PI_Q29 / 2) / PI_Q29;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1;

		add_pair(0, 0, 0, 0);
		add_pair(900000000, 0, -900000000, 0);
		add_pair(0, 0, 0, 1800000000);
		add_pair(0, -1800000000, 0, 1800000000);
		add_pair(0, 0, 0, 900000000);
		add_pair(-900000000, 1800000000, 900000000, -1800000000);
		add_pair(450000000, 100000000, -450000000, -1700000000);
		add_pair(1073741823, 2147483647, -1073741824, -2147483648);
		add_pair(-1073741824, -2147483648, 1073741823, 2147483647);
		add_pair(1200000000, 0, 0, 0);
		add_pair(1073741823, 0, 1073741823, 0);
		add_pair(0, 0, 1, 0);
		add_pair(0, 0, 0, 1);
		add_pair(899999999, 0, 900000000, 1800000000);
		add_pair(377749000, -1224194000, 517500000, -1278000);
		add_pair(-338688000, 1512093000, 407128000, -740060000);
		add_pair(0, 0, 0, 1799999999);
		add_pair(100000000, 200000000, -100000000, -1600000000);
		add_pair(-1, -1, 0, 0);
		add_pair(0, 2147483647, 0, -2147483648);
		drain();

		foreach (radii[ph]) begin
			write_radius(radii[ph]);
			if (ph == 1) hold_token <= hold_token + 1;
			if (ph == 5) calm = 1;
			for (int n = 0; n < 320; n++) pending_pairs.push_back(random_pair());
			drain();
		end

		$display("%0d position pairs accepted, %0d distances checked over 7 radius settings",
			accepted, checked);
		$display("including zero, maximum and reset radius, long output hold and random gaps");
		if (mismatches == 0 && expected_dist.size() == 0) begin
			$display("[great_circle_distance_top] OK");
		end else begin
			$display("[great_circle_distance_top] ERROR");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("[great_circle_distance_top] ERROR");
		$finish;
	end

endmodule

>>> files.f
src/gcd_pkg.sv
src/gcd_sincos.sv
src/gcd_root.sv
src/great_circle_distance_top.sv
verif/tb_top.sv
